>>> rtl/block_working_set_tracker_assert.svh
// Assertion macros for the working set tracker.
`ifndef BLOCK_WORKING_SET_TRACKER_ASSERT_SVH
`define BLOCK_WORKING_SET_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define BWST_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define BWST_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define BWST_ASSERT(label, clk, rst_n, prop)
`define BWST_ASSERT_NR(label, clk, prop)
`endif
`endif

>>> rtl/bwst_pkg.sv
package bwst_pkg;

  typedef struct packed {
    logic        req_type;
    logic [19:0] start_block;
    logic [8:0]  block_count;
  } req_t;

  typedef struct packed {
    logic [20:0] touched_blocks;
    logic [20:0] read_blocks;
    logic [20:0] written_blocks;
    logic [20:0] rewritten_blocks;
    logic [19:0] lowest_block;
    logic [19:0] highest_block;
    logic        bounds_valid;
    logic        range_clipped;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_MODIFY,
    ST_WRITE,
    ST_DONE
  } state_e;

  localparam logic [19:0] BLOCK_MAX = 20'hFFFFF;

endpackage

>>> rtl/block_working_set_tracker.sv
// channel | signals                       | payload
// request | req_valid_i / req_ready_o     | req_i (bwst_pkg::req_t)
// result  | rsp_valid_o / rsp_ready_i     | rsp_o (bwst_pkg::rsp_t)
// After reset a clearing pass wipes the maps one word at a time, TRACKED_BLOCKS/MAP_WORD_BITS words
// (16384 by default); no request is taken meanwhile.
// A request steps each map word it spans (up to 5 words) through read, wait, modify and write,
// one word at a time through the single read-modify-write port of the bitmap memory.
// A zero-length or fully out-of-range request goes from idle straight to the done state.
// Hold the next request until the previous result word is accepted.
module block_working_set_tracker #(
  parameter int TRACKED_BLOCKS     = 1048576,
  parameter int MAX_REQUEST_BLOCKS = 256,
  parameter int MAP_WORD_BITS      = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  bwst_pkg::req_t  req_i,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i,
  output bwst_pkg::rsp_t  rsp_o
);
  import bwst_pkg::*;
`include "block_working_set_tracker_assert.svh"

  localparam int Words = (TRACKED_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int AW    = (Words > 1) ? $clog2(Words) : 1;
  localparam int BW    = $clog2(MAP_WORD_BITS);
  localparam int IncW  = $clog2(MAP_WORD_BITS + 1);
  localparam int LimW  = $clog2(MAX_REQUEST_BLOCKS + 1);
  localparam int PosW  = 32;
  localparam int MW    = 4 * MAP_WORD_BITS;

  logic [MW-1:0] mem [Words];
  logic [MW-1:0] rd_q;

  state_e state_q, state_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic            is_write_q;
  logic [PosW-1:0] cur_q, cur_d;
  logic [PosW-1:0] last_q;
  logic            clip_q;
  logic [20:0] tc_q, rc_q, wc_q, rwc_q;
  logic [19:0] lo_q, hi_q;
  logic        seen_q;
  logic [MW-1:0] wr_data_q;
  logic [IncW-1:0] ti_q, ri_q, wi_q, rwi_q;
  logic rsp_valid_q;

  logic [PosW-1:0] len_sat, start_ext, end_full;
  logic [19:0]     end_sat;
  logic [AW-1:0]   word_addr;
  logic [BW-1:0]   lo_bit, hi_bit;
  logic [PosW-1:0] word_last;
  logic [PosW-1:0] seg_end;
  logic [MAP_WORD_BITS-1:0] mask;
  logic [MAP_WORD_BITS-1:0] t_n, r_n, w_n, rw_n;
  logic [IncW-1:0] t_i, r_i, w_i, rw_i;
  logic accept;

  assign accept = req_valid_i && req_ready_o;

  always_comb begin
    len_sat = (32'(req_i.block_count) > 32'(MAX_REQUEST_BLOCKS)) ?
              32'(MAX_REQUEST_BLOCKS) : 32'(req_i.block_count);
    start_ext = 32'(req_i.start_block);
    end_full  = start_ext + len_sat - 32'd1;
    end_sat   = (end_full > 32'(BLOCK_MAX)) ? BLOCK_MAX : end_full[19:0];
  end

  always_comb begin
    word_addr = AW'(cur_q / MAP_WORD_BITS);
    lo_bit    = BW'(cur_q % MAP_WORD_BITS);
    word_last = cur_q - 32'(lo_bit) + 32'(MAP_WORD_BITS - 1);
    seg_end   = (last_q < word_last) ? last_q : word_last;
    hi_bit    = BW'(seg_end % MAP_WORD_BITS);
    for (int i = 0; i < MAP_WORD_BITS; i++) begin
      mask[i] = (BW'(i) >= lo_bit) && (BW'(i) <= hi_bit);
    end
  end

  bwst_map_word #(.WordBits(MAP_WORD_BITS)) u_word (
    .touched_i    (rd_q[0*MAP_WORD_BITS +: MAP_WORD_BITS]),
    .read_i       (rd_q[1*MAP_WORD_BITS +: MAP_WORD_BITS]),
    .write_i      (rd_q[2*MAP_WORD_BITS +: MAP_WORD_BITS]),
    .rewrite_i    (rd_q[3*MAP_WORD_BITS +: MAP_WORD_BITS]),
    .mask_i       (mask),
    .is_write_i   (is_write_q),
    .touched_o    (t_n),
    .read_o       (r_n),
    .write_o      (w_n),
    .rewrite_o    (rw_n),
    .touched_inc_o(t_i),
    .read_inc_o   (r_i),
    .write_inc_o  (w_i),
    .rewrite_inc_o(rw_i)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cur_d       = cur_q;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (32'(clr_q) == 32'(Words - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        req_ready_o = !rsp_valid_q || rsp_ready_i;
        if (accept) begin
          cur_d = start_ext;
          if (len_sat == 32'd0 || start_ext >= 32'(TRACKED_BLOCKS)) state_d = ST_DONE;
          else state_d = ST_READ;
        end
      end
      ST_READ:   state_d = ST_WAIT;
      ST_WAIT:   state_d = ST_MODIFY;
      ST_MODIFY: state_d = ST_WRITE;
      ST_WRITE: begin
        cur_d = seg_end + 32'd1;
        if (seg_end == last_q) state_d = ST_DONE;
        else state_d = ST_READ;
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cur_q       <= '0;
      tc_q        <= '0;
      rc_q        <= '0;
      wc_q        <= '0;
      rwc_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      seen_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cur_q   <= cur_d;
      if (rsp_valid_q && rsp_ready_i) rsp_valid_q <= 1'b0;
      if (accept && len_sat != 32'd0) begin
        seen_q <= 1'b1;
        if (!seen_q) begin
          lo_q <= req_i.start_block;
          hi_q <= end_sat;
        end else begin
          if (end_sat > hi_q) hi_q <= end_sat;
          if (req_i.start_block < lo_q) lo_q <= req_i.start_block;
        end
      end
      if (state_q == ST_WRITE) begin
        tc_q  <= tc_q + 21'(ti_q);
        rc_q  <= rc_q + 21'(ri_q);
        wc_q  <= wc_q + 21'(wi_q);
        rwc_q <= rwc_q + 21'(rwi_q);
      end
      if (state_q == ST_DONE) rsp_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      is_write_q <= req_i.req_type;
      clip_q     <= (len_sat != 32'd0) && (end_full >= 32'(TRACKED_BLOCKS));
      last_q     <= (end_full >= 32'(TRACKED_BLOCKS)) ? 32'(TRACKED_BLOCKS - 1) : end_full;
    end
    if (state_q == ST_READ) rd_q <= mem[word_addr];
    if (state_q == ST_MODIFY) begin
      wr_data_q <= {rw_n, w_n, r_n, t_n};
      ti_q      <= t_i;
      ri_q      <= r_i;
      wi_q      <= w_i;
      rwi_q     <= rw_i;
    end
    if (state_q == ST_CLEAR) mem[clr_q] <= '0;
    else if (state_q == ST_WRITE) mem[word_addr] <= wr_data_q;
  end

  always_comb begin
    rsp_o.touched_blocks   = tc_q;
    rsp_o.read_blocks      = rc_q;
    rsp_o.written_blocks   = wc_q;
    rsp_o.rewritten_blocks = rwc_q;
    rsp_o.lowest_block     = lo_q;
    rsp_o.highest_block    = hi_q;
    rsp_o.bounds_valid     = seen_q;
    rsp_o.range_clipped    = clip_q;
  end
  assign rsp_valid_o = rsp_valid_q;

  `BWST_ASSERT(a_ready_idle, clk_i, rst_ni, req_ready_o |-> state_q == ST_IDLE)
  `BWST_ASSERT(a_done_valid, clk_i, rst_ni, state_q == ST_DONE |=> rsp_valid_o)
  `BWST_ASSERT(a_rewrite_le_write, clk_i, rst_ni, state_q == ST_IDLE |-> (rwc_q <= wc_q || wc_q < 21'(LimW)))
  `BWST_ASSERT(a_bounds_order, clk_i, rst_ni, seen_q |-> lo_q <= hi_q)
endmodule

>>> rtl/bwst_map_word.sv
module bwst_map_word #(
  parameter int WordBits = 64
) (
  input  logic [WordBits-1:0]          touched_i,
  input  logic [WordBits-1:0]          read_i,
  input  logic [WordBits-1:0]          write_i,
  input  logic [WordBits-1:0]          rewrite_i,
  input  logic [WordBits-1:0]          mask_i,
  input  logic                         is_write_i,
  output logic [WordBits-1:0]          touched_o,
  output logic [WordBits-1:0]          read_o,
  output logic [WordBits-1:0]          write_o,
  output logic [WordBits-1:0]          rewrite_o,
  output logic [$clog2(WordBits+1)-1:0] touched_inc_o,
  output logic [$clog2(WordBits+1)-1:0] read_inc_o,
  output logic [$clog2(WordBits+1)-1:0] write_inc_o,
  output logic [$clog2(WordBits+1)-1:0] rewrite_inc_o
);
  localparam int IncW = $clog2(WordBits + 1);

  logic [WordBits-1:0] t_new, r_new, w_new, rw_new;

  always_comb begin
    t_new  = mask_i & ~touched_i;
    r_new  = is_write_i ? '0 : (mask_i & ~read_i);
    w_new  = is_write_i ? (mask_i & ~write_i) : '0;
    rw_new = is_write_i ? (mask_i & write_i & ~rewrite_i) : '0;
    touched_o = touched_i | t_new;
    read_o    = read_i | r_new;
    write_o   = write_i | w_new;
    rewrite_o = rewrite_i | rw_new;
    touched_inc_o = IncW'($countones(t_new));
    read_inc_o    = IncW'($countones(r_new));
    write_inc_o   = IncW'($countones(w_new));
    rewrite_inc_o = IncW'($countones(rw_new));
  end
endmodule
